FILE: sv/swu_pkg.sv
package swu_pkg;

  // field widths fixed by the transaction format
  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 7;
  localparam int LOG_W   = WORD_W + 1;

  // default sizes
  localparam int STACK_DEPTH_DEF = 64;
  localparam int LOG_DEPTH_DEF   = 64;

  // operation codes
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_UNDO = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;
  localparam logic [1:0] ST_NO_UNDO   = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] push_value;
  } swu_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] result_value;
    logic                     undid_push;
    logic [DEPTH_W-1:0]       stack_depth;
  } swu_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } swu_cmd_t;

endpackage

FILE: sv/swu_ram.sv
module swu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/swu_ctrl.sv
module swu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output swu_pkg::swu_cmd_t cmd
);
  import swu_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // accept while idle; execute in the cycle after memory reads are issued
  assign cmd.capture = start && !busy;
  assign cmd.execute = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/swu_dpath.sv
module swu_dpath #(
  parameter int STACK_DEPTH = swu_pkg::STACK_DEPTH_DEF,
  parameter int LOG_DEPTH   = swu_pkg::LOG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  swu_pkg::swu_cmd_t cmd,
  input  swu_pkg::swu_in_t  req,
  output logic              done,
  output swu_pkg::swu_out_t rsp
);
  import swu_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = $clog2(LOG_DEPTH);
  localparam int LCW = $clog2(LOG_DEPTH + 1);

  swu_in_t         op;
  logic [SCW-1:0]  stack_count;
  logic [LAW-1:0]  log_newest;
  logic [LCW-1:0]  log_count;

  logic [SCW-1:0]  stack_count_next;
  logic [LAW-1:0]  log_newest_next;
  logic [LCW-1:0]  log_count_next;

  logic              s_we;
  logic [SAW-1:0]    s_waddr;
  logic [WORD_W-1:0] s_wdata;
  logic [SAW-1:0]    s_raddr;
  logic [WORD_W-1:0] s_rdata;
  logic              l_we;
  logic [LAW-1:0]    l_waddr;
  logic [LOG_W-1:0]  l_wdata;
  logic [LOG_W-1:0]  l_rdata;

  logic [SCW-1:0]    top_index;
  logic [LAW-1:0]    newest_inc;
  logic [LAW-1:0]    newest_dec;
  logic              stack_full;
  logic              stack_empty;
  logic              log_full;
  logic              was_push;
  logic [1:0]        st;
  logic [WORD_W-1:0] val;
  logic              undid;
  logic [SCW+DEPTH_W-1:0] depth_wide;

  // stack and log memories
  swu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we && cmd.execute),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  swu_ram #(.WIDTH(LOG_W), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (l_we && cmd.execute),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (log_newest),
    .rdata (l_rdata)
  );

  // read addresses: top of stack and newest log record
  assign top_index = stack_count - SCW'(1);
  assign s_raddr   = top_index[SAW-1:0];

  // ring pointer steps
  assign newest_inc = (log_newest == LAW'(LOG_DEPTH - 1)) ? '0 : log_newest + LAW'(1);
  assign newest_dec = (log_newest == '0) ? LAW'(LOG_DEPTH - 1) : log_newest - LAW'(1);

  assign stack_full  = (stack_count >= SCW'(STACK_DEPTH));
  assign stack_empty = (stack_count == '0);
  assign log_full    = (log_count >= LCW'(LOG_DEPTH));
  assign was_push    = l_rdata[WORD_W];

  // operation decode and next state
  always_comb begin
    st               = ST_OK;
    val              = '0;
    undid            = 1'b0;
    stack_count_next = stack_count;
    log_newest_next  = log_newest;
    log_count_next   = log_count;
    s_we             = 1'b0;
    s_waddr          = stack_count[SAW-1:0];
    s_wdata          = op.push_value;
    l_we             = 1'b0;
    l_waddr          = newest_inc;
    l_wdata          = {1'b1, op.push_value};
    case (op.mode)
      MODE_PUSH: begin
        if (stack_full) begin
          st = ST_PUSH_FULL;
        end else begin
          s_we             = 1'b1;
          stack_count_next = stack_count + SCW'(1);
          l_we             = 1'b1;
          log_newest_next  = newest_inc;
          log_count_next   = log_full ? log_count : log_count + LCW'(1);
        end
      end
      MODE_POP: begin
        if (stack_empty) begin
          st = ST_POP_EMPTY;
        end else begin
          val              = s_rdata;
          stack_count_next = top_index;
          l_we             = 1'b1;
          l_wdata          = {1'b0, s_rdata};
          log_newest_next  = newest_inc;
          log_count_next   = log_full ? log_count : log_count + LCW'(1);
        end
      end
      MODE_UNDO: begin
        if (log_count == '0 || (was_push && stack_empty) || (!was_push && stack_full)) begin
          st = ST_NO_UNDO;
        end else begin
          if (was_push) begin
            val              = s_rdata;
            undid            = 1'b1;
            stack_count_next = top_index;
          end else begin
            val              = l_rdata[WORD_W-1:0];
            s_we             = 1'b1;
            s_wdata          = l_rdata[WORD_W-1:0];
            stack_count_next = stack_count + SCW'(1);
          end
          log_newest_next = newest_dec;
          log_count_next  = log_count - LCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // depth field keeps the low bits of the count
  assign depth_wide = {{DEPTH_W{1'b0}}, stack_count_next};

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= req;
    end
  end

  // pointers and result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      log_newest  <= '0;
      log_count   <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.execute;
      if (cmd.execute) begin
        stack_count <= stack_count_next;
        log_newest  <= log_newest_next;
        log_count   <= log_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp.status       <= st;
      rsp.result_value <= val;
      rsp.undid_push   <= undid;
      rsp.stack_depth  <= depth_wide[DEPTH_W-1:0];
    end
  end

  // checks
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_log_bound: assert property (@(posedge clk) disable iff (rst)
    log_count <= LCW'(LOG_DEPTH) && log_newest <= LAW'(LOG_DEPTH - 1))
    else $error("log pointer or count out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && op.mode == MODE_PUSH && !stack_full
    |=> stack_count == SCW'($past(stack_count) + SCW'(1)))
    else $error("accepted push did not grow the stack");

  a_undo_empty_log: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && op.mode == MODE_UNDO && log_count == '0
    |=> stack_count == $past(stack_count) && log_newest == $past(log_newest)
        && rsp.status == ST_NO_UNDO)
    else $error("undo with empty log changed state");

endmodule

FILE: sv/stack_with_undo_log_top.sv
// Bounded stack of signed words with an undo log. Each transaction is a push, pop or
// undo of the newest logged push or pop; the log is a ring that overwrites its oldest
// record when full. A transaction is taken when start is high and busy is low; busy
// then stays high until the transaction has executed. The result is registered on rsp
// with done high for exactly one cycle, after the execute state that follows capture of
// the request. The receiver cannot stall, so rsp must be taken while done is high. A new
// transaction is not taken before the last one has executed: first comes the registered
// read of the stack top and newest log record, then the update of both memories and the
// pointers.
module stack_with_undo_log_top #(
  parameter int STACK_DEPTH = swu_pkg::STACK_DEPTH_DEF,
  parameter int LOG_DEPTH   = swu_pkg::LOG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  swu_pkg::swu_in_t  req,
  output logic              done,
  output swu_pkg::swu_out_t rsp
);
  import swu_pkg::*;

  swu_cmd_t cmd;

  // sequencing
  swu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // stack, log and result registers
  swu_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOG_DEPTH   (LOG_DEPTH)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

endmodule
